/* sv/ata_cis_pkg.sv */
// Package for the ATA command issue sequencer: payload structs, opcode and
// register id constants, and the command classification tables.
// No dependencies.
package ata_cis_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int NUM_WORDS = 5;
	localparam logic [3:0] LAST_STEP = 4'd12;

	// Configuration register indexes
	localparam logic CFG_DRIVE0_PRESENT = 1'b0;
	localparam logic CFG_DRIVE1_PRESENT = 1'b1;

	// Opcodes that get special handling
	localparam logic [7:0] OP_DEVICE_RESET = 8'h08;
	localparam logic [7:0] OP_EXEC_DIAG = 8'h90;
	localparam logic [7:0] OP_INIT_PARAMS = 8'h91;
	localparam logic [7:0] OP_PACKET = 8'ha0;
	localparam logic [7:0] OP_IDENTIFY_PACKET = 8'ha1;
	localparam logic [7:0] OP_READ_DMA = 8'hc8;
	localparam logic [7:0] OP_READ_DMA_EXT = 8'h25;
	localparam logic [7:0] OP_SECURITY = 8'h8e;
	localparam logic [7:0] OP_SMART = 8'hb0;

	// Pseudo register ids
	localparam logic [7:0] REG_NONE = 8'h00;
	localparam logic [7:0] REG_CONTROL = 8'h6a;
	localparam logic [7:0] REG_FEATURE = 8'h92;
	localparam logic [7:0] REG_COUNT = 8'h52;
	localparam logic [7:0] REG_SECTOR = 8'hd2;
	localparam logic [7:0] REG_CYL_LOW = 8'h32;
	localparam logic [7:0] REG_CYL_HIGH = 8'hb2;
	localparam logic [7:0] REG_SELECT = 8'h72;
	localparam logic [7:0] REG_COMMAND = 8'hf2;

	localparam logic [7:0] CTRL_NO_TIMEOUT = 8'h02;
	localparam logic [7:0] CTRL_TIMEOUT = 8'h00;

	localparam logic [3:0] TYPE_NONE = 4'd0;
	localparam logic [3:0] TYPE_1 = 4'd1;
	localparam logic [3:0] TYPE_2 = 4'd2;
	localparam logic [3:0] TYPE_3 = 4'd3;
	localparam logic [3:0] TYPE_DMA = 4'd4;
	localparam logic [3:0] TYPE_5 = 4'd5;
	localparam logic [3:0] TYPE_6 = 4'd6;
	localparam logic [3:0] TYPE_7 = 4'd7;
	localparam logic [3:0] TYPE_8 = 4'd8;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_DRIVE = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] feature_word;
		logic [15:0] sector_count_word;
		logic [15:0] sector_number_word;
		logic [15:0] cylinder_low_word;
		logic [15:0] cylinder_high_word;
		logic [7:0]  drive_select;
		logic [7:0]  command_code;
		logic        drive_ready;
	} req_item_t;

	typedef struct packed {
		logic [7:0] reg_id;
		logic [7:0] reg_value;
		status_t    status;
		logic [3:0] command_type;
		logic       uses_timeout;
		logic       transfer_dir;
		logic       last;
	} rsp_item_t;

	// Classified request handed from the front end to the back end
	typedef struct packed {
		status_t                    status;
		logic [3:0]                 cmd_type;
		logic                       timeout;
		logic                       dir;
		logic [NUM_WORDS-1:0][15:0] words;
		logic [7:0]                 sel;
		logic [7:0]                 cmd;
	} job_t;

	function automatic logic [3:0] main_type(input logic [7:0] code);
		logic [3:0] t;
		case (code)
			8'h00, 8'h03, 8'h40, 8'h70, 8'h91, 8'hc0, 8'hc6, 8'hda, 8'hde, 8'hdf,
			8'he0, 8'he1, 8'he2, 8'he3, 8'he5, 8'he6, 8'he7, 8'hed, 8'hef, 8'hf3,
			8'hf5, 8'hf8, 8'hf9, 8'hea: t = TYPE_1;
			8'h20, 8'h87, 8'ha1, 8'hc4, 8'he4, 8'hec: t = TYPE_2;
			8'h30, 8'h38, 8'h92, 8'hc5, 8'hcd, 8'he8, 8'hf1, 8'hf2, 8'hf4,
			8'hf6: t = TYPE_3;
			8'hc8, 8'hca, 8'h25, 8'h35: t = TYPE_DMA;
			8'h08: t = TYPE_5;
			8'h90: t = TYPE_6;
			8'h8e, 8'hb0: t = TYPE_7;
			8'h32: t = TYPE_8;
			default: t = TYPE_NONE;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] security_type(input logic [7:0] code);
		logic [3:0] t;
		case (code)
			8'hec, 8'h20: t = TYPE_2;
			8'hf3, 8'hf4, 8'hf5: t = TYPE_1;
			8'hf1, 8'hf2, 8'h30: t = TYPE_3;
			default: t = TYPE_NONE;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] smart_type(input logic [7:0] code);
		logic [3:0] t;
		case (code)
			8'hd0, 8'hd5: t = TYPE_2;
			8'hd2, 8'hd3, 8'hd4, 8'hd8, 8'hd9, 8'hda: t = TYPE_1;
			8'hd6: t = TYPE_3;
			default: t = TYPE_NONE;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] word_reg_id(input logic [2:0] idx);
		logic [7:0] id;
		case (idx)
			3'd0: id = REG_FEATURE;
			3'd1: id = REG_COUNT;
			3'd2: id = REG_SECTOR;
			3'd3: id = REG_CYL_LOW;
			3'd4: id = REG_CYL_HIGH;
			default: id = REG_NONE;
		endcase
		return id;
	endfunction

endpackage

/* sv/ata_cis_front.sv */
// Front end: classifies an incoming request (drive presence, opcode type,
// readiness, timeout, direction) and holds the configuration registers.
// Depends on ata_cis_pkg.
module ata_cis_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic                   cfg_data,
	input  logic                   accept,
	input  ata_cis_pkg::req_item_t req,
	output ata_cis_pkg::job_t      job
);
	import ata_cis_pkg::*;

	logic       drive0_q;
	logic       drive1_q;
	logic       dir_q;
	logic       present;
	logic       ready_ok;
	logic [3:0] ty;
	logic [7:0] feat_lo;
	logic       new_dir;

	always_comb begin
		feat_lo = req.feature_word[7:0];
		present = req.drive_select[4] ? drive1_q : drive0_q;
		if (req.command_code == OP_SECURITY) begin
			ty = security_type(feat_lo);
		end else if (req.command_code == OP_SMART) begin
			ty = smart_type(feat_lo);
		end else begin
			ty = main_type(req.command_code);
		end
		ready_ok = req.drive_ready || req.command_code == OP_DEVICE_RESET ||
			req.command_code == OP_EXEC_DIAG || req.command_code == OP_INIT_PARAMS ||
			req.command_code == OP_PACKET || req.command_code == OP_IDENTIFY_PACKET;

		job.words = {req.cylinder_high_word, req.cylinder_low_word,
			req.sector_number_word, req.sector_count_word, req.feature_word};
		job.sel = req.drive_select;
		job.cmd = req.command_code;
		job.timeout = 1'b0;
		job.cmd_type = ty;
		new_dir = dir_q;
		if (!present) begin
			job.status = ST_NO_DRIVE;
			job.cmd_type = TYPE_NONE;
		end else if (ty == TYPE_NONE) begin
			job.status = ST_UNKNOWN;
		end else if (!ready_ok) begin
			job.status = ST_NOT_READY;
		end else begin
			job.status = ST_OK;
			job.timeout = ty == TYPE_1 || ty == TYPE_DMA || ty == TYPE_6;
			if (ty == TYPE_DMA) begin
				new_dir = !(req.command_code == OP_READ_DMA ||
					req.command_code == OP_READ_DMA_EXT);
			end
		end
		// The direction reported with a request is the one stored after it.
		job.dir = new_dir;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive0_q <= 1'b0;
			drive1_q <= 1'b0;
			dir_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_DRIVE0_PRESENT) begin
				drive0_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_DRIVE1_PRESENT) begin
				drive1_q <= cfg_data;
			end
			if (accept) begin
				dir_q <= new_dir;
			end
		end
	end

endmodule

/* sv/ata_cis_fifo.sv */
// Small register queue between the front and back ends.
// Depends on nothing beyond its parameters.
module ata_cis_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign level = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/ata_cis_back.sv */
// Back end: walks a classified request through its register writes into an
// output register, one per cycle unless stalled on pop. Depends on ata_cis_pkg.
module ata_cis_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	input  ata_cis_pkg::job_t       job,
	output logic                    job_done,
	input  logic                    pop,
	output logic                    empty,
	output ata_cis_pkg::rsp_item_t  rsp,
	output logic [3:0]              step
);
	import ata_cis_pkg::*;

	logic [3:0] step_q;
	logic       out_valid_q;
	rsp_item_t  rsp_q;
	rsp_item_t  nxt;
	logic       adv;
	logic [2:0] hi_idx;
	logic [2:0] lo_idx;

	assign adv = !out_valid_q || pop;
	assign job_done = adv && job_valid && nxt.last;
	assign empty = !out_valid_q;
	assign rsp = rsp_q;
	assign step = step_q;

	always_comb begin
		hi_idx = 3'(step_q - 4'd1);
		lo_idx = 3'(step_q - 4'd6);
		nxt.status = job.status;
		nxt.command_type = job.cmd_type;
		nxt.uses_timeout = job.timeout;
		nxt.transfer_dir = job.dir;
		nxt.last = 1'b0;
		nxt.reg_id = REG_NONE;
		nxt.reg_value = 8'h00;
		if (job.status != ST_OK) begin
			nxt.last = 1'b1;
		end else begin
			case (step_q)
				4'd0: begin
					nxt.reg_id = REG_CONTROL;
					nxt.reg_value = job.timeout ? CTRL_TIMEOUT : CTRL_NO_TIMEOUT;
				end
				4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
					nxt.reg_id = word_reg_id(hi_idx);
					nxt.reg_value = job.words[hi_idx][15:8];
				end
				4'd6, 4'd7, 4'd8, 4'd9, 4'd10: begin
					nxt.reg_id = word_reg_id(lo_idx);
					nxt.reg_value = job.words[lo_idx][7:0];
				end
				4'd11: begin
					nxt.reg_id = REG_SELECT;
					nxt.reg_value = job.sel;
				end
				LAST_STEP: begin
					nxt.reg_id = REG_COMMAND;
					nxt.reg_value = job.cmd;
					nxt.last = 1'b1;
				end
				default: begin
					nxt.last = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv && job_valid) begin
			rsp_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= job_valid;
			if (job_valid) begin
				step_q <= nxt.last ? 4'd0 : step_q + 4'd1;
			end
		end
	end

endmodule

/* sv/ata_command_issue_sequencer_core.sv */
// Top level of the ATA command issue sequencer: front end, request queue
// and back end. Depends on ata_cis_pkg, ata_cis_front, ata_cis_fifo, ata_cis_back.
//
//   channel  | direction | handshake              | payload
//   request  | in        | push / full            | req (req_item_t)
//   result   | out       | empty / pop            | rsp (rsp_item_t)
//   config   | in        | cfg_we                 | cfg_index, cfg_data
//
// An accepted request yields thirteen register writes, one per cycle while
// results are popped, or a single reject result; the step counter walks them.
// Requests are classified in the cycle they arrive and wait in a queue of
// QUEUE_DEPTH entries, so push is taken while results are still draining.
// A result sits in an output register until popped; a stalled pop holds the
// back end and, once the queue fills, raises full. Reset clears the queue,
// the configuration and the stored direction.
module ata_command_issue_sequencer_core #(
	parameter int QUEUE_DEPTH = ata_cis_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  ata_cis_pkg::req_item_t req,
	output logic                   empty,
	input  logic                   pop,
	output ata_cis_pkg::rsp_item_t rsp,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic                   cfg_data
);
	import ata_cis_pkg::*;

	localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

	job_t             new_job;
	job_t             head_job;
	logic [$bits(job_t)-1:0] head_bits;
	logic             accept;
	logic             q_empty;
	logic             job_done;
	logic [LVL_W-1:0] q_level;
	logic [3:0]       step;

	assign accept = push && !full;
	assign head_job = job_t'(head_bits);

	ata_cis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.req       (req),
		.job       (new_job)
	);

	ata_cis_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (new_job),
		.rd_en   (job_done),
		.rd_data (head_bits),
		.full    (full),
		.empty   (q_empty),
		.level   (q_level)
	);

	ata_cis_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_empty),
		.job       (head_job),
		.job_done  (job_done),
		.pop       (pop),
		.empty     (empty),
		.rsp       (rsp),
		.step      (step)
	);

`ifndef SYNTH
	// A sequence in progress always has its request at the queue head.
	a_step_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		step != 4'd0 |-> !q_empty)
		else $error("write sequence in progress with an empty queue");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step <= LAST_STEP)
		else $error("write step counter out of range");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= LVL_W'(QUEUE_DEPTH))
		else $error("queue level beyond its depth");

	// A rejected request produces exactly one result, marked last.
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.status != ST_OK |-> rsp.last)
		else $error("reject result without last");
`endif

endmodule
